FILE: design/drrip_pkg.sv
// ----------------------------------------------------------------------------
// DRRIP/SHiP replacement package
// Shared sizes, state type and helpers.
// ----------------------------------------------------------------------------
package drrip_pkg;
  localparam int NumSets       = 2048;
  localparam int NumWays       = 16;
  localparam int SigBits       = 6;
  localparam int DuelLeaders   = 64;
  localparam int StreamLeaders = 32;
  localparam int SetBits       = $clog2(NumSets);
  localparam int WayBits       = $clog2(NumWays);
  localparam int SigEntries    = 1 << SigBits;
  localparam int RowBits       = NumWays * 2;
  localparam int SigRowBits    = NumWays * SigBits;
  localparam int StrideBits    = 64 + 64 + 3;
  localparam logic [9:0] PselInit = 10'd512;
  localparam logic [9:0] PselMax  = 10'd1023;
  localparam logic [2:0] RepMax   = 3'd7;
  localparam logic [1:0] RrpvMax  = 2'd3;

  localparam logic CfgStream = 1'b0;
  localparam logic CfgReuse  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_AGE, ST_WRITE, ST_OUT
  } state_t;

  function automatic logic [SigBits-1:0] sig_hash(input logic [63:0] pc);
    sig_hash = SigBits'(pc ^ (pc >> SigBits) ^ (pc >> (2 * SigBits)));
  endfunction
endpackage

FILE: design/drrip_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module drrip_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: design/drrip_ship_stream_replacement.sv
// ----------------------------------------------------------------------------
// DRRIP + SHiP replacement with stride stream detection
// Per-access victim choice and insertion RRPV for a set-associative cache.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries one cache access per
//    transaction. Output channel (out_valid/out_ready) returns one result:
//    target way, inserted RRPV and the streaming flag.
//  - Config channel (cfg_valid/cfg_ready) writes stream_threshold (index 0)
//    or reuse_threshold (index 1).
//  - Hits and misses with an invalid way pass READ, AGE and WRITE from
//    accept to out_valid; a miss that must age the set stays in AGE longer
//    (one aging step of all ways in parallel per cycle).
//  - Accesses do not overlap: in_ready is low while an access is in work
//    or its result waits in the output register, so a new access is taken
//    only after the previous result has been taken.
//  - After reset a clearing pass walks all NumSets rows, zeroing RRPV,
//    signature, stride rows and the reuse counter table; no access is
//    taken then. Config writes are taken at any time.
//  - A stalled receiver simply holds the result; nothing is lost.
// ----------------------------------------------------------------------------
module drrip_ship_stream_replacement (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] set_index,
  input  logic        is_hit,
  input  logic [3:0]  hit_way,
  input  logic [15:0] valid_ways,
  input  logic [63:0] pc,
  input  logic [63:0] addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  target_way,
  output logic [1:0]  inserted_rrpv,
  output logic        streaming,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);
  import drrip_pkg::*;

  state_t state, state_next;
  logic [SetBits-1:0] clr_cnt;

  // captured access
  logic [SetBits-1:0] set_q;
  logic               hit_q;
  logic [WayBits-1:0] hway_q;
  logic [15:0]        valid_q;
  logic [SigBits-1:0] sig_q;
  logic [63:0]        addr_q;

  logic [2:0] stream_thr;
  logic [1:0] reuse_thr;
  logic [9:0] psel;
  logic [15:0] lfsr;
  logic [1:0] reuse_cur;   // counter of the access signature

  // working row
  logic [RowBits-1:0] row;
  logic               strm;

  // RAMs
  logic                  ram_we;
  logic [SetBits-1:0]    ram_waddr, ram_raddr;
  logic [RowBits-1:0]    rrpv_wdata, rrpv_rdata;
  logic [SigRowBits-1:0] sig_wdata, sig_rdata;
  logic [StrideBits-1:0] str_wdata, str_rdata;
  logic [SigBits-1:0]    reuse_waddr, reuse_raddr;
  logic [1:0]            reuse_wdata, reuse_rdata;

  drrip_ram #(.Width(RowBits), .Depth(NumSets)) u_rrpv (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(rrpv_wdata),
    .raddr(ram_raddr), .rdata(rrpv_rdata));
  drrip_ram #(.Width(SigRowBits), .Depth(NumSets)) u_sig (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(sig_wdata),
    .raddr(ram_raddr), .rdata(sig_rdata));
  drrip_ram #(.Width(StrideBits), .Depth(NumSets)) u_stride (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(str_wdata),
    .raddr(ram_raddr), .rdata(str_rdata));
  drrip_ram #(.Width(2), .Depth(SigEntries)) u_reuse (
    .clk, .we(ram_we), .waddr(reuse_waddr), .wdata(reuse_wdata),
    .raddr(reuse_raddr), .rdata(reuse_rdata));

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign cfg_ready = 1'b1;
  wire in_acc = in_valid && in_ready;

  // row read at accept, then held on the captured set so read data stays put
  assign ram_raddr = (state == ST_IDLE) ? set_index : set_q;

  // stride detector, from the row read
  logic [63:0] prev_addr, last_str, stride;
  logic [2:0]  reps, reps_new;
  assign prev_addr = str_rdata[StrideBits-1 -: 64];
  assign last_str  = str_rdata[66:3];
  assign reps      = str_rdata[2:0];
  assign stride    = addr_q - prev_addr;
  always_comb begin
    if (last_str != 64'd0 && stride == last_str)
      reps_new = (reps < RepMax) ? reps + 3'd1 : reps;
    else
      reps_new = 3'd0;
  end

  // victim search: first invalid, else first RRPV 3 in working row
  logic               any_inv, any_max;
  logic [WayBits-1:0] inv_way, max_way;
  always_comb begin
    any_inv = 1'b0; inv_way = '0; any_max = 1'b0; max_way = '0;
    for (int w = NumWays - 1; w >= 0; w--) begin
      if (w >= 16 || !valid_q[w]) begin
        any_inv = 1'b1; inv_way = WayBits'(w);
      end
      if (row[2*w +: 2] == RrpvMax) begin
        any_max = 1'b1; max_way = WayBits'(w);
      end
    end
  end

  // insertion policy
  logic in_stream_ld, in_srrip_ld, in_brrip_ld;
  assign in_stream_ld = set_q >= SetBits'(NumSets/4) &&
                        set_q <  SetBits'(NumSets/4 + StreamLeaders);
  assign in_srrip_ld  = set_q <  SetBits'(DuelLeaders);
  assign in_brrip_ld  = set_q >= SetBits'(NumSets/2) &&
                        ({1'b0, set_q} < (SetBits+1)'(NumSets/2 + DuelLeaders));

  logic [15:0] lfsr_step;
  assign lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ 16'hB400) : (lfsr >> 1);
  logic [1:0] brrip_ins;
  assign brrip_ins = (lfsr_step[4:0] == 5'd0) ? 2'd2 : 2'd3;

  logic [1:0] ins;
  logic       use_brrip;
  logic       psel_up, psel_dn;
  always_comb begin
    use_brrip = 1'b0; psel_up = 1'b0; psel_dn = 1'b0; ins = 2'd2;
    if (in_stream_ld && strm) begin
      ins = 2'd3; psel_up = 1'b1;
    end else if (in_srrip_ld) begin
      ins = 2'd2; psel_up = 1'b1;
    end else if (in_brrip_ld) begin
      use_brrip = 1'b1; ins = brrip_ins; psel_dn = 1'b1;
    end else if (psel < PselInit) begin
      ins = 2'd2;
    end else begin
      use_brrip = 1'b1; ins = brrip_ins;
    end
    if (reuse_cur >= reuse_thr && !strm) ins = 2'd0;
  end

  logic [WayBits-1:0] way_sel;
  assign way_sel = hit_q ? hway_q : (any_inv ? inv_way : max_way);
  logic [SigBits-1:0] old_sig;
  assign old_sig = sig_rdata[SigBits*way_sel +: SigBits];

  // reuse table: access signature read at accept, victim's old signature
  // read in the last AGE cycle, one write-back in WRITE
  always_comb begin
    if (state == ST_IDLE)     reuse_raddr = sig_hash(pc);
    else if (state == ST_AGE) reuse_raddr = old_sig;
    else                      reuse_raddr = sig_q;
  end
  assign reuse_waddr = (state == ST_CLEAR) ? clr_cnt[SigBits-1:0] :
                       (hit_q ? sig_q : old_sig);
  always_comb begin
    if (state == ST_CLEAR)
      reuse_wdata = 2'd0;
    else if (hit_q)
      reuse_wdata = (reuse_cur == 2'd3) ? reuse_cur : reuse_cur + 2'd1;
    else
      reuse_wdata = (reuse_rdata == 2'd0) ? reuse_rdata : reuse_rdata - 2'd1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == SetBits'(NumSets - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_acc) state_next = ST_READ;
      ST_READ:  state_next = ST_AGE;
      ST_AGE:   if (hit_q || any_inv || any_max) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  logic [RowBits-1:0] row_w;
  always_comb begin
    row_w = row;
    row_w[2*way_sel +: 2] = hit_q ? 2'd0 : ins;
  end
  logic [SigRowBits-1:0] sig_w;
  always_comb begin
    sig_w = sig_rdata;
    if (!hit_q) sig_w[SigBits*way_sel +: SigBits] = sig_q;
  end

  assign ram_we     = (state == ST_CLEAR) || (state == ST_WRITE);
  assign ram_waddr  = (state == ST_CLEAR) ? clr_cnt : set_q;
  assign rrpv_wdata = (state == ST_CLEAR) ? '0 : row_w;
  assign sig_wdata  = (state == ST_CLEAR) ? '0 : sig_w;
  assign str_wdata  = (state == ST_CLEAR) ? '0 : {addr_q, stride, reps_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      stream_thr <= 3'd4;
      reuse_thr <= 2'd2;
      psel <= PselInit;
      lfsr <= 16'd1;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + SetBits'(1);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgStream) stream_thr <= cfg_data;
        else reuse_thr <= cfg_data[1:0];
      end
      if (state == ST_WRITE && !hit_q) begin
        if (use_brrip) lfsr <= lfsr_step;
        if (psel_up && psel < PselMax) psel <= psel + 10'd1;
        if (psel_dn && psel != 10'd0) psel <= psel - 10'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      set_q <= set_index; hit_q <= is_hit; hway_q <= hit_way;
      valid_q <= valid_ways; sig_q <= sig_hash(pc); addr_q <= addr;
    end
    if (state == ST_READ) begin
      row       <= rrpv_rdata;
      strm      <= reps_new >= stream_thr;
      reuse_cur <= reuse_rdata;
    end else if (state == ST_AGE && !(hit_q || any_inv || any_max)) begin
      for (int w = 0; w < NumWays; w++) row[2*w +: 2] <= row[2*w +: 2] + 2'd1;
    end
    if (state == ST_WRITE) begin
      target_way    <= way_sel;
      inserted_rrpv <= hit_q ? 2'd0 : ins;
      streaming     <= strm;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(target_way))
    else $error("result dropped under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_clear: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_ready)
    else $error("input taken during clearing pass");
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DRRIP/SHiP replacement testbench
// Drives random and directed cache accesses through the valid/ready ports.
// A scoreboard class predicts each result and compares it with the block.
// Threshold registers are rewritten between phases while the block idles.
// ----------------------------------------------------------------------------
module tb;
  import drrip_pkg::*;

  // Scoreboard: shadow replacement state plus a queue of predicted results
  class repl_scoreboard;
    bit [1:0]  rrpv   [NumSets*NumWays];
    bit [5:0]  sig_of [NumSets*NumWays];
    bit [1:0]  reuse  [SigEntries];
    bit [63:0] last_a [NumSets];
    bit [63:0] last_s [NumSets];
    bit [2:0]  reps   [NumSets];
    bit [9:0]  psel;
    bit [15:0] lfsr;
    bit [2:0]  stream_thr;
    bit [1:0]  reuse_thr;
    bit [6:0]  pending[$];
    int        errors;

    function new();
      psel = PselInit; lfsr = 16'd1; stream_thr = 3'd4; reuse_thr = 2'd2;
      errors = 0;
    endfunction

    function bit [1:0] brrip_pick();
      bit lsb;
      lsb = lfsr[0];
      lfsr = lfsr >> 1;
      if (lsb) lfsr = lfsr ^ 16'hB400;
      return (lfsr[4:0] == 5'd0) ? 2'd2 : 2'd3;
    endfunction

    function void note_access(bit [10:0] set, bit hit, bit [3:0] hway, bit [15:0] vm,
                              bit [63:0] p, bit [63:0] a);
      int base, way;
      bit [5:0] sg, old;
      bit [63:0] stride;
      bit strm;
      bit [1:0] mx, ins;
      base = set * NumWays;
      sg = 6'(p ^ (p >> 6) ^ (p >> 12));
      stride = a - last_a[set];
      if (last_s[set] != 0 && stride == last_s[set]) begin
        if (reps[set] < 7) reps[set]++;
      end else begin
        reps[set] = 0;
      end
      last_s[set] = stride;
      last_a[set] = a;
      strm = reps[set] >= stream_thr;
      if (hit) begin
        rrpv[base+hway] = 0;
        if (reuse[sg] < 3) reuse[sg]++;
        pending.insert(pending.size(), {hway, 2'd0, strm});
        return;
      end
      way = -1;
      for (int w = 0; w < NumWays; w++)
        if (way < 0 && !vm[w]) way = w;
      if (way < 0) begin
        mx = 0;
        for (int w = 0; w < NumWays; w++) if (rrpv[base+w] > mx) mx = rrpv[base+w];
        for (int w = 0; w < NumWays; w++) rrpv[base+w] += 2'(3 - mx);
        for (int w = 0; w < NumWays; w++)
          if (way < 0 && rrpv[base+w] == 3) way = w;
        if (way < 0) way = 0;
      end
      if (set >= NumSets/4 && set < NumSets/4 + StreamLeaders && strm) begin
        ins = 3; if (psel < PselMax) psel++;
      end else if (set < DuelLeaders) begin
        ins = 2; if (psel < PselMax) psel++;
      end else if (set >= NumSets/2 && set < NumSets/2 + DuelLeaders) begin
        ins = brrip_pick(); if (psel > 0) psel--;
      end else if (psel < PselInit) begin
        ins = 2;
      end else begin
        ins = brrip_pick();
      end
      if (reuse[sg] >= reuse_thr && !strm) ins = 0;
      old = sig_of[base+way];
      sig_of[base+way] = sg;
      rrpv[base+way] = ins;
      if (reuse[old] > 0) reuse[old]--;
      pending.insert(pending.size(), {4'(way), ins, strm});
    endfunction

    function void check_result(bit [3:0] tw, bit [1:0] ir, bit st);
      bit [6:0] e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: way %0d", tw);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e[6:3] != tw) begin
        $error("target_way exp %0d got %0d", e[6:3], tw); errors++;
      end
      if (e[2:1] != ir) begin
        $error("inserted_rrpv exp %0d got %0d", e[2:1], ir); errors++;
      end
      if (e[0] != st) begin
        $error("streaming exp %0d got %0d", e[0], st); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic [10:0] set_index = 0;
  logic is_hit = 0;
  logic [3:0] hit_way = 0;
  logic [15:0] valid_ways = 0;
  logic [63:0] pc = 0, addr = 0;
  logic out_valid, out_ready = 0;
  logic [3:0] target_way;
  logic [1:0] inserted_rrpv;
  logic streaming;
  logic cfg_valid = 0, cfg_ready;
  logic cfg_index = 0;
  logic [2:0] cfg_data = 0;

  repl_scoreboard sb = new();
  int idle_cycles = 0;
  int rx_phase = 0;
  localparam int WatchLimit = 20000;  // covers the clearing pass

  always #5 clk = ~clk;

  drrip_ship_stream_replacement u_top (.*);

  // Receiver: stall pattern with quiet stretches
  always @(negedge clk) begin
    int m;
    m = ($urandom_range(0, 7) == 0) ? 1 : 0;
    rx_phase <= rx_phase + 1;
    if (rx_phase % 64 < 20) out_ready <= 1'b1;
    else out_ready <= (m == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  // Monitor and watchdog at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result(target_way, inserted_rrpv, streaming);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(bit idx, bit [2:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgStream) sb.stream_thr = val;
    else sb.reuse_thr = val[1:0];
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // One access transaction; holds valid until accepted
  task automatic send_access(bit [10:0] s, bit h, bit [3:0] hw, bit [15:0] vm,
                             bit [63:0] p, bit [63:0] a);
    @(negedge clk);
    in_valid <= 1; set_index <= s; is_hit <= h; hit_way <= hw;
    valid_ways <= vm; pc <= p; addr <= a;
    do @(posedge clk); while (!in_ready);
    sb.note_access(s, h, hw, vm, p, a);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Random access: mostly set-focused streams over a few hot sets
  task automatic random_access(bit [10:0] hot[4]);
    bit [10:0] s;
    bit [63:0] a;
    int k;
    k = $urandom_range(0, 9);
    s = (k < 7) ? hot[$urandom_range(0, 3)] : 11'($urandom);
    if ($urandom_range(0, 1)) a = sb.last_a[s] + sb.last_s[s];
    else a = {$urandom, $urandom};
    if ($urandom_range(0, 5) == 0) a = sb.last_a[s] + 64'($urandom_range(1, 4) * 64);
    send_access(s, $urandom_range(0, 2) == 0, 4'($urandom),
                ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'hFFFF,
                {$urandom, $urandom} & (($urandom_range(0, 1)) ? 64'h3F : '1), a);
  endtask

  initial begin
    bit [10:0] hot[4];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    write_reg(CfgStream, 3'd4);
    write_reg(CfgReuse, 3'd2);
    // Directed: extremes of fields, hits, misses, leader regions, streams
    send_access(11'd0, 0, 0, 16'h0000, 64'd0, 64'd0);
    send_access(11'd2047, 0, 4'd15, 16'hFFFF, '1, '1);
    send_access(11'd2047, 1, 4'd15, 16'hFFFF, '1, 64'd5);
    send_access(11'd1024, 0, 0, 16'hFFFF, 64'h123, 64'h40);
    send_access(11'd1024, 0, 0, 16'h7FFF, 64'h123, 64'h80);
    for (int i = 0; i < 8; i++)
      send_access(11'd512, 0, 0, 16'hFFFF, 64'h77, 64'(i * 64));
    for (int i = 0; i < 4; i++)
      send_access(11'd5, 1, 4'(i), 16'hFFFF, 64'h9, 64'(i * 8));
    send_access(11'd5, 0, 0, 16'hFFFF, 64'h9, 64'h1000);
    send_access(11'd700, 0, 0, 16'h8000, 64'hA5A5, 64'h77);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CfgStream, 3'd0); write_reg(CfgReuse, 3'd0); end
        1: begin write_reg(CfgStream, 3'd7); write_reg(CfgReuse, 3'd3); end
        2: begin write_reg(CfgStream, 3'd2); write_reg(CfgReuse, 3'd1); end
        3: begin write_reg(CfgStream, 3'd4); write_reg(CfgReuse, 3'd2); end
        default: begin write_reg(CfgStream, 3'd1); write_reg(CfgReuse, 3'd3); end
      endcase
      hot[0] = 11'($urandom_range(0, 63));
      hot[1] = 11'($urandom_range(512, 543));
      hot[2] = 11'($urandom_range(1024, 1087));
      hot[3] = 11'($urandom);
      for (int n = 0; n < 100;) begin
        int burst;
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < 100; b++, n++) random_access(hot);
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
